// ===== sv/tts_pkg.sv =====
// Shared types and codes for the tick task slot scheduler.
`default_nettype none
package tts_pkg;

  localparam logic [1:0] FUNC_ADD  = 2'd0;
  localparam logic [1:0] FUNC_TICK = 2'd1;
  localparam logic [1:0] FUNC_RUN  = 2'd2;
  localparam logic [1:0] FUNC_NOP  = 2'd3;

  localparam logic [2:0] KIND_ADDED = 3'd0;
  localparam logic [2:0] KIND_FULL  = 3'd1;
  localparam logic [2:0] KIND_TICK  = 3'd2;
  localparam logic [2:0] KIND_RUN   = 3'd3;
  localparam logic [2:0] KIND_NONE  = 3'd4;

  localparam int unsigned MAX_RES = 8;
  localparam int unsigned NW      = 4;

  localparam logic signed [31:0] CD_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] CD_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic               valid;
    logic [15:0]        task_id;
    logic signed [31:0] countdown;
    logic signed [31:0] period;
  } slot_t;

  typedef struct packed {
    logic [1:0] op;
    logic       found;
    logic       room;
  } head_ctl_t;

  typedef struct packed {
    logic ready;
    logic take;
  } head_sts_t;

endpackage
`default_nettype wire

// ===== sv/tick_task_slot_scheduler.sv =====
// Top level of the tick task slot scheduler: slot ring, head unit and result register.
// Slots live in a ring of SLOTS cells that rotates one place per cycle past a single
// head unit, except while a result waits for the result side, so each slot is visited in
// index order and the ring is back in place after SLOTS shifts. An item holds the input
// from its acceptance through SLOTS rotation steps and the posting of the closing result;
// a rotation step or the closing result waits while a result cannot be handed to the
// result side. Func 3 items do not hold the input and give no result. Add, tick and
// dispatch each close with a result marked last; a dispatch reports up to eight ready
// slots, one per result.
`default_nettype none
module tick_task_slot_scheduler #(
  parameter int unsigned SLOTS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_func,
  input  wire logic [15:0] in_task_id,
  input  wire logic [31:0] in_start_delay,
  input  wire logic [31:0] in_period,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_kind,
  output logic [2:0]       out_slot,
  output logic [15:0]      out_run_id,
  output logic             out_last
);
  import tts_pkg::*;

  localparam int unsigned CW = $clog2(SLOTS + 1);

  slot_t ring [SLOTS];
  slot_t head_nrec;
  slot_t add_rec;
  head_ctl_t hctl;
  head_sts_t hsts;

  logic          busy_r, busy_nxt;
  logic [1:0]    op_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic          found_r, found_nxt;
  logic [2:0]    found_idx_r, found_idx_nxt;
  logic          pend_v_r, pend_v_nxt;
  logic [2:0]    pend_slot_r, pend_slot_nxt;
  logic [15:0]   pend_id_r, pend_id_nxt;
  logic [15:0]   task_r;
  logic [31:0]   delay_r;
  logic [31:0]   per_r;

  logic          out_valid_r;
  logic [2:0]    out_kind_r, out_kind_nxt;
  logic [2:0]    out_slot_r, out_slot_nxt;
  logic [15:0]   out_id_r, out_id_nxt;
  logic          out_last_r, out_last_nxt;

  logic          shift;
  logic          push;
  logic          out_free;
  logic          accept;
  logic [CW+2:0] cnt_ext;
  logic [2:0]    idx;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = busy_r;
  assign accept   = in_valid && !busy_r;
  assign cnt_ext  = {3'b000, cnt_r};
  assign idx      = cnt_ext[2:0];

  assign add_rec = '{valid: 1'b1, task_id: task_r, countdown: delay_r, period: per_r};
  assign hctl    = '{op: op_r, found: found_r, room: (n_r < NW'(MAX_RES))};

  genvar g;
  generate
    for (g = 0; g < SLOTS; g++) begin : g_cell
      slot_t d;
      if (g == SLOTS - 1) begin : g_tail
        assign d = head_nrec;
      end else begin : g_mid
        assign d = ring[g+1];
      end
      tts_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .shift (shift),
        .d     (d),
        .q     (ring[g])
      );
    end
  endgenerate

  tts_head u_head (
    .rec     (ring[0]),
    .add_rec (add_rec),
    .ctl     (hctl),
    .nrec    (head_nrec),
    .sts     (hsts)
  );

  always_comb begin
    busy_nxt      = busy_r;
    cnt_nxt       = cnt_r;
    n_nxt         = n_r;
    found_nxt     = found_r;
    found_idx_nxt = found_idx_r;
    pend_v_nxt    = pend_v_r;
    pend_slot_nxt = pend_slot_r;
    pend_id_nxt   = pend_id_r;
    shift         = 1'b0;
    push          = 1'b0;
    out_kind_nxt  = KIND_RUN;
    out_slot_nxt  = pend_slot_r;
    out_id_nxt    = pend_id_r;
    out_last_nxt  = 1'b0;
    if (accept) begin
      busy_nxt   = (in_func != FUNC_NOP);
      cnt_nxt    = '0;
      n_nxt      = '0;
      found_nxt  = 1'b0;
      pend_v_nxt = 1'b0;
    end else if (busy_r && cnt_r < CW'(SLOTS)) begin
      if (!(hsts.ready && pend_v_r) || out_free) begin
        push  = hsts.ready && pend_v_r;
        shift = 1'b1;
        cnt_nxt = cnt_r + CW'(1);
        if (hsts.take) begin
          found_nxt     = 1'b1;
          found_idx_nxt = idx;
        end
        if (hsts.ready) begin
          n_nxt         = n_r + NW'(1);
          pend_v_nxt    = 1'b1;
          pend_slot_nxt = idx;
          pend_id_nxt   = ring[0].task_id;
        end
      end
    end else if (busy_r) begin
      if (out_free) begin
        push         = 1'b1;
        busy_nxt     = 1'b0;
        out_last_nxt = 1'b1;
        out_slot_nxt = 3'd0;
        out_id_nxt   = 16'd0;
        unique case (op_r)
          FUNC_ADD: begin
            out_kind_nxt = found_r ? KIND_ADDED : KIND_FULL;
            out_slot_nxt = found_r ? found_idx_r : 3'd0;
          end
          FUNC_TICK: begin
            out_kind_nxt = KIND_TICK;
          end
          default: begin
            out_kind_nxt = pend_v_r ? KIND_RUN : KIND_NONE;
            out_slot_nxt = pend_v_r ? pend_slot_r : 3'd0;
            out_id_nxt   = pend_v_r ? pend_id_r : 16'd0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      op_r        <= FUNC_ADD;
      cnt_r       <= '0;
      n_r         <= '0;
      found_r     <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      cnt_r    <= cnt_nxt;
      n_r      <= n_nxt;
      found_r  <= found_nxt;
      pend_v_r <= pend_v_nxt;
      if (accept) begin
        op_r <= in_func;
      end
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    found_idx_r <= found_idx_nxt;
    pend_slot_r <= pend_slot_nxt;
    pend_id_r   <= pend_id_nxt;
    if (accept) begin
      task_r  <= in_task_id;
      delay_r <= in_start_delay;
      per_r   <= in_period;
    end
    if (push) begin
      out_kind_r <= out_kind_nxt;
      out_slot_r <= out_slot_nxt;
      out_id_r   <= out_id_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_kind   = out_kind_r;
  assign out_slot   = out_slot_r;
  assign out_run_id = out_id_r;
  assign out_last   = out_last_r;

  a_pend_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    pend_v_r |-> op_r == FUNC_RUN)
    else $error("pending run result outside a dispatch");

  a_found_add: assert property (@(posedge clk) disable iff (!rst_n)
    found_r |-> op_r == FUNC_ADD)
    else $error("free slot claimed outside an add");

  a_run_limit: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= NW'(MAX_RES))
    else $error("dispatch reported too many ready slots");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(SLOTS))
    else $error("ring step count past the slot count");

  a_push_ok: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> out_free)
    else $error("result pushed over a held result");

endmodule
`default_nettype wire

// ===== sv/tts_cell.sv =====
// One slot cell of the rotating slot ring.
`default_nettype none
module tts_cell (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          shift,
  input  wire tts_pkg::slot_t d,
  output tts_pkg::slot_t     q
);
  import tts_pkg::*;

  logic               valid_r;
  logic [15:0]        task_r;
  logic signed [31:0] cd_r;
  logic signed [31:0] per_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (shift) begin
      valid_r <= d.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      task_r <= d.task_id;
      cd_r   <= d.countdown;
      per_r  <= d.period;
    end
  end

  assign q = '{valid: valid_r, task_id: task_r, countdown: cd_r, period: per_r};

endmodule
`default_nettype wire

// ===== sv/tts_head.sv =====
// Head unit: applies the current operation to the slot leaving the ring head.
`default_nettype none
module tts_head (
  input  wire tts_pkg::slot_t    rec,
  input  wire tts_pkg::slot_t    add_rec,
  input  wire tts_pkg::head_ctl_t ctl,
  output tts_pkg::slot_t         nrec,
  output tts_pkg::head_sts_t     sts
);
  import tts_pkg::*;

  logic signed [32:0] sum;

  assign sum = {rec.countdown[31], rec.countdown} + {rec.period[31], rec.period};

  always_comb begin
    nrec      = rec;
    sts.ready = 1'b0;
    sts.take  = 1'b0;
    case (ctl.op)
      FUNC_ADD: begin
        if (!ctl.found && !rec.valid) begin
          nrec     = add_rec;
          sts.take = 1'b1;
        end
      end
      FUNC_TICK: begin
        if (rec.valid && rec.countdown != CD_MIN) begin
          nrec.countdown = rec.countdown - 32'sd1;
        end
      end
      FUNC_RUN: begin
        if (rec.valid && rec.countdown <= 32'sd0 && ctl.room) begin
          sts.ready = 1'b1;
          if (rec.period > 32'sd0) begin
            nrec.countdown = (sum[32] != sum[31]) ? CD_MAX : sum[31:0];
          end else begin
            nrec.valid = 1'b0;
          end
        end
      end
      default: begin
        nrec = rec;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== verif/tick_task_slot_scheduler_tb.sv =====
// Self-checking testbench for the tick task slot scheduler: directed table, random items.
module tick_task_slot_scheduler_tb;
  import tts_pkg::*;

  localparam int NSLOT = 8;
  localparam int DIR_N = 23;
  localparam int RAND_ITEMS = 145;
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_CYCLES = 30;
  localparam longint LIMIT = 2_000_000;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  slot;
    logic [15:0] run_id;
    logic        last;
  } sched_res_t;

  typedef struct packed {
    logic [1:0]         func;
    logic [15:0]        task_id;
    logic signed [31:0] start_delay;
    logic signed [31:0] period;
    logic               chk;
    logic [2:0]         kind;
    logic [2:0]         slot;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_func = FUNC_ADD;
  logic [15:0] in_task_id = '0;
  logic [31:0] in_start_delay = '0;
  logic [31:0] in_period = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_kind;
  logic [2:0]  out_slot;
  logic [15:0] out_run_id;
  logic        out_last;

  // receiver controls
  logic out_hold = 1'b0;
  logic rx_calm = 1'b0;
  int   rx_wait = 0;
  bit   fast = 1'b0;

  // predictor copy of the slot table
  logic               sv_valid [NSLOT];
  logic [15:0]        sv_task  [NSLOT];
  logic signed [31:0] sv_cd    [NSLOT];
  logic signed [31:0] sv_per   [NSLOT];

  sched_res_t due_q [$];
  sched_res_t got;
  sched_res_t want;
  dir_row_t   dir_tab [DIR_N];

  int n_errors = 0;
  int n_results = 0;
  int n_full = 0;
  int widest = 0;
  int op_cnt [4] = '{0, 0, 0, 0};

  tick_task_slot_scheduler #(.SLOTS(NSLOT)) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_task_id     (in_task_id),
    .in_start_delay (in_start_delay),
    .in_period      (in_period),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_slot       (out_slot),
    .out_run_id     (out_run_id),
    .out_last       (out_last)
  );

  always #6 clk = ~clk;

  task automatic report_err(input string msg);
    n_errors++;
    if (n_errors <= 30) $display("ERROR @%0t: %s", $time, msg);
  endtask

  function automatic sched_res_t mk_res(logic [2:0] k, logic [2:0] s, logic [15:0] id,
                                        logic l);
    sched_res_t res;
    res.kind = k;
    res.slot = s;
    res.run_id = id;
    res.last = l;
    return res;
  endfunction

  function automatic dir_row_t row_pred(logic [1:0] f, logic [15:0] id,
                                        logic signed [31:0] sd, logic signed [31:0] per);
    dir_row_t r;
    r.func = f;
    r.task_id = id;
    r.start_delay = sd;
    r.period = per;
    r.chk = 1'b0;
    r.kind = '0;
    r.slot = '0;
    return r;
  endfunction

  function automatic dir_row_t row_known(logic [1:0] f, logic [15:0] id,
                                         logic signed [31:0] sd, logic signed [31:0] per,
                                         logic [2:0] k, logic [2:0] s);
    dir_row_t r;
    r = row_pred(f, id, sd, per);
    r.chk = 1'b1;
    r.kind = k;
    r.slot = s;
    return r;
  endfunction

  // Works out the results of one item and updates the slot table copy.
  task automatic sched_predict(input dir_row_t r, input bit post);
    sched_res_t held;
    int k;
    int n;
    longint acc;
    n = 0;
    case (r.func)
      FUNC_ADD: begin
        k = 0;
        while (k < NSLOT && sv_valid[k]) k++;
        if (k < NSLOT) begin
          sv_valid[k] = 1'b1;
          sv_task[k] = r.task_id;
          sv_cd[k] = r.start_delay;
          sv_per[k] = r.period;
          held = mk_res(KIND_ADDED, k[2:0], 16'h0, 1'b1);
        end else begin
          held = mk_res(KIND_FULL, 3'd0, 16'h0, 1'b1);
          n_full++;
        end
        if (post) due_q.push_back(held);
      end
      FUNC_TICK: begin
        for (k = 0; k < NSLOT; k++)
          if (sv_valid[k] && sv_cd[k] != CD_MIN) sv_cd[k] = sv_cd[k] - 1;
        if (post) due_q.push_back(mk_res(KIND_TICK, 3'd0, 16'h0, 1'b1));
      end
      FUNC_RUN: begin
        for (k = 0; k < NSLOT && n < MAX_RES; k++) begin
          if (sv_valid[k] && sv_cd[k] <= 0) begin
            if (n > 0 && post) due_q.push_back(held);
            held = mk_res(KIND_RUN, k[2:0], sv_task[k], 1'b0);
            n++;
            if (sv_per[k] > 0) begin
              acc = longint'(sv_cd[k]) + longint'(sv_per[k]);
              sv_cd[k] = (acc > longint'(CD_MAX)) ? CD_MAX : acc[31:0];
            end else begin
              sv_valid[k] = 1'b0;
            end
          end
        end
        if (n == 0) held = mk_res(KIND_NONE, 3'd0, 16'h0, 1'b1);
        else held.last = 1'b1;
        if (n > widest) widest = n;
        if (post) due_q.push_back(held);
      end
      default: ;
    endcase
  endtask

  function automatic dir_row_t rand_row();
    logic [1:0]         f;
    logic signed [31:0] sd;
    logic signed [31:0] per;
    int                 pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) f = FUNC_ADD;
    else if (pick < 65) f = FUNC_TICK;
    else if (pick < 95) f = FUNC_RUN;
    else f = FUNC_NOP;
    pick = $urandom_range(0, 79);
    if (pick == 0) sd = CD_MIN;
    else if (pick == 1) sd = CD_MAX;
    else if (pick < 8) sd = $urandom | 32'h8000_0000;
    else if (pick == 8) sd = $urandom;
    else sd = int'($urandom_range(0, 8)) - 2;
    pick = $urandom_range(0, 79);
    if (pick == 0) per = CD_MIN;
    else if (pick == 1) per = CD_MAX;
    else if (pick < 8) per = $urandom | 32'h8000_0000;
    else if (pick == 8) per = $urandom;
    else if (pick < 40) per = $urandom_range(1, 6);
    else per = int'($urandom_range(0, 3)) - 3;
    return row_pred(f, 16'($urandom), sd, per);
  endfunction

  task automatic send_item(input dir_row_t r);
    int gap;
    gap = fast ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= r.func;
    in_task_id <= r.task_id;
    in_start_delay <= r.start_delay;
    in_period <= r.period;
    do @(posedge clk); while (in_stall !== 1'b0);
    sched_predict(r, !r.chk);
    if (r.chk) due_q.push_back(mk_res(r.kind, r.slot, 16'h0, 1'b1));
    op_cnt[r.func]++;
  endtask

  // result side: check, then draw the next stall
  always @(posedge clk) begin
    if (out_valid === 1'b1 && out_stall === 1'b0) begin
      got = mk_res(out_kind, out_slot, out_run_id, out_last);
      n_results++;
      if (due_q.size() == 0) begin
        report_err($sformatf("unexpected item kind=%0d slot=%0d id=%h last=%b",
                             got.kind, got.slot, got.run_id, got.last));
      end else begin
        want = due_q.pop_front();
        if (got.kind !== want.kind)
          report_err($sformatf("kind %0d, expected %0d", got.kind, want.kind));
        if (got.slot !== want.slot)
          report_err($sformatf("slot %0d, expected %0d", got.slot, want.slot));
        if (got.run_id !== want.run_id)
          report_err($sformatf("run_id %h, expected %h", got.run_id, want.run_id));
        if (got.last !== want.last)
          report_err($sformatf("last %b, expected %b", got.last, want.last));
      end
      rx_wait = rx_calm ? 0 : $urandom_range(0, 5);
    end else if (rx_wait != 0) begin
      rx_wait = rx_wait - 1;
    end
    out_stall <= out_hold || (rx_wait != 0);
  end

  initial begin
    #(LIMIT);
    $display("Timeout with %0d items outstanding", due_q.size());
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int       i;
    dir_row_t r;
    for (i = 0; i < NSLOT; i++) begin
      sv_valid[i] = 1'b0;
      sv_task[i] = '0;
      sv_cd[i] = '0;
      sv_per[i] = '0;
    end
    dir_tab[0]  = row_known(FUNC_RUN, 16'h0, 0, 0, KIND_NONE, 3'd0);
    dir_tab[1]  = row_known(FUNC_TICK, 16'h0, 0, 0, KIND_TICK, 3'd0);
    dir_tab[2]  = row_known(FUNC_ADD, 16'hffff, CD_MIN, 0, KIND_ADDED, 3'd0);
    dir_tab[3]  = row_known(FUNC_ADD, 16'h0000, CD_MAX, CD_MAX, KIND_ADDED, 3'd1);
    dir_tab[4]  = row_known(FUNC_TICK, 16'h0, 0, 0, KIND_TICK, 3'd0);
    dir_tab[5]  = row_pred(FUNC_RUN, 16'h0, 0, 0);
    dir_tab[6]  = row_pred(FUNC_ADD, 16'h1234, 0, CD_MAX);
    dir_tab[7]  = row_pred(FUNC_ADD, 16'ha5a5, CD_MIN, 1);
    dir_tab[8]  = row_pred(FUNC_ADD, 16'h5a5a, 1, -1);
    dir_tab[9]  = row_pred(FUNC_ADD, 16'h0007, -1, CD_MIN);
    dir_tab[10] = row_pred(FUNC_RUN, 16'h0, 0, 0);
    dir_tab[11] = row_pred(FUNC_RUN, 16'h0, 0, 0);
    dir_tab[12] = row_pred(FUNC_NOP, 16'hffff, -1, -1);
    dir_tab[13] = row_pred(FUNC_TICK, 16'h0, 0, 0);
    dir_tab[14] = row_pred(FUNC_RUN, 16'h0, 0, 0);
    dir_tab[15] = row_pred(FUNC_ADD, 16'h0101, 0, 0);
    dir_tab[16] = row_pred(FUNC_ADD, 16'h0202, 0, 0);
    dir_tab[17] = row_pred(FUNC_ADD, 16'h0404, 0, 0);
    dir_tab[18] = row_pred(FUNC_ADD, 16'h0808, 0, 0);
    dir_tab[19] = row_pred(FUNC_ADD, 16'h1010, 0, 0);
    dir_tab[20] = row_known(FUNC_ADD, 16'hbeef, 5, 5, KIND_FULL, 3'd0);
    dir_tab[21] = row_pred(FUNC_TICK, 16'h0, 0, 0);
    dir_tab[22] = row_pred(FUNC_RUN, 16'h0, 0, 0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < DIR_N; i++) send_item(dir_tab[i]);

    i = 0;
    while (i < RAND_ITEMS) begin
      r = rand_row();
      send_item(r);
      if (r.func != FUNC_NOP) begin
        i++;
        if (i == 60) begin
          // long receiver hold while items keep coming
          fast = 1'b1;
          fork
            begin
              out_hold <= 1'b1;
              repeat (HOLD_CYCLES) @(posedge clk);
              out_hold <= 1'b0;
            end
          join_none
        end
        if (i == 76) fast = 1'b0;
        if (i == 110) begin
          fast = 1'b1;
          rx_calm <= 1'b1;
        end
        if (i == 135) begin
          fast = 1'b0;
          rx_calm <= 1'b0;
        end
      end
    end
    in_valid <= 1'b0;

    while (due_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d adds, %0d ticks, %0d dispatches, %0d unused ops; %0d results checked",
             op_cnt[FUNC_ADD], op_cnt[FUNC_TICK], op_cnt[FUNC_RUN], op_cnt[FUNC_NOP],
             n_results);
    $display("Table-full replies: %0d, most tasks run by one dispatch: %0d, mismatches: %0d",
             n_full, widest, n_errors);
    if (n_errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
